[hdl/scgw_pkg.sv]
package scgw_pkg;

    localparam int GRID_MAX = 20;
    localparam int MAX_OUT  = 2 * GRID_MAX - 1;
    localparam int CNT_W    = $clog2(MAX_OUT + 1);
    localparam int IDX_W    = 5;

    typedef enum logic [2:0] {
        CFG_ZONE_EN   = 3'd0,
        CFG_X_LOW     = 3'd1,
        CFG_Z_LOW     = 3'd2,
        CFG_X_HIGH    = 3'd3,
        CFG_Z_HIGH    = 3'd4,
        CFG_CELL_SIZE = 3'd5,
        CFG_COLS      = 3'd6,
        CFG_ROWS      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               start;
        logic signed [63:0] dividend;
        logic signed [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
        logic signed [31:0] rem;
    } t_div_rsp;

endpackage

[hdl/scgw_div.sv]
module scgw_div
    import scgw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_dsv;
    logic        r_qneg;
    logic        r_rneg;

    logic [32:0] w_sh;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_sh   = {r_rem, r_quo[63]};
    assign w_diff = w_sh - {1'b0, r_dsv};
    assign w_ge   = (w_sh >= {1'b0, r_dsv});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend[63] ? 64'(-i_req.dividend) : 64'(i_req.dividend);
                r_dsv  <= i_req.divisor[31] ? 32'(-i_req.divisor) : 32'(i_req.divisor);
                r_qneg <= i_req.dividend[63] ^ i_req.divisor[31];
                r_rneg <= i_req.dividend[63];
            end else if (r_busy) begin
                // one restoring step per cycle
                r_rem <= w_ge ? w_diff[31:0] : w_sh[31:0];
                r_quo <= {r_quo[62:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_qneg ? -$signed(r_quo[31:0]) : $signed(r_quo[31:0]);
    assign o_rsp.rem  = r_rneg ? -$signed(r_rem) : $signed(r_rem);

endmodule

[hdl/segment_clip_grid_walk_top.sv]
// channel   dir  signals                                  contents
// s_axis    in   s_axis_tvalid/tready/tdata[127:0]        segment endpoints
// m_axis    out  m_axis_tvalid/tready/tdata[15:0]/tuser   at most one visited cell per transfer
//                /tlast
// cfg       in   i_cfg_we/i_cfg_idx/i_cfg_data            register writes, no read-back
//
// one segment at a time: s_axis_tready is high only while idle
// a clipped segment runs up to eight clip divisions plus six cell divisions through one
// shared divider, then walks the grid and reports each visited cell
// rejected segments skip the divider, point segments use two divisions
// synchronous active-low reset initialises control and configuration
// the walk stalls while the output register holds an untaken cell
module segment_clip_grid_walk_top
    import scgw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // seg_start_x, seg_start_z, seg_end_x, seg_end_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,   // cell_column, cell_row, zero pad
    output logic         m_axis_tuser,   // cell_valid
    output logic         m_axis_tlast,   // last_cell
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_CLIP, S_CELL, S_DSTART, S_DWAIT, S_PTEND,
        S_PREP, S_MULZ, S_MULX, S_ACC, S_WALK, S_FIN
    } t_state;

    typedef enum logic [3:0] {
        PH_CLIP, PH_PTX, PH_PTZ, PH_SCX, PH_SCZ, PH_ECX, PH_ECZ, PH_ADJZ, PH_ADJX
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic               r_zone_en;
    logic signed [31:0] r_x_low, r_z_low, r_x_high, r_z_high;
    logic [30:0]        r_cell_size;
    logic [4:0]         r_cols, r_rows;

    logic signed [31:0] r_sx, r_sz, r_ex, r_ez;
    logic signed [31:0] r_cx, r_cz, r_ecx, r_ecz, r_remx, r_remz;
    logic signed [31:0] r_dx, r_dz, r_adjz, r_adjx, r_acc, r_base;
    logic               r_stx_neg, r_stz_neg;
    logic [2:0]         r_k;
    logic signed [63:0] r_dvnd;
    logic signed [31:0] r_dvsr;
    logic [CNT_W-1:0]   r_n;

    logic               r_have_pend;
    logic [IDX_W-1:0]   r_pcol, r_prow;

    logic               r_ovalid, r_ouser, r_olast;
    logic [IDX_W-1:0]   r_ocol, r_orow;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic signed [31:0] w_cs, w_ncols, w_nrows;
    logic [4:0]         w_cols, w_rows;
    logic               w_can_push;
    logic               w_opush;

    logic               cl_cond;
    logic signed [31:0] cl_a, cl_b, cl_c, cl_base;
    logic signed [31:0] w_clip_val;
    logic               w_clip_wr;

    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;

    logic signed [31:0] w_offx, w_offz, w_offex, w_offez;
    logic signed [31:0] w_pcx, w_pcz, w_dx, w_dz, w_errx, w_errz;
    logic               w_reject, w_in_grid;

    function automatic logic in_grid(input logic signed [31:0] cx, input logic signed [31:0] cz,
                                     input logic signed [31:0] nc, input logic signed [31:0] nr);
        return (cx >= 32'sd0) && (cx < nc) && (cz >= 32'sd0) && (cz < nr);
    endfunction

    assign w_cs    = (r_cell_size == 31'd0) ? 32'sd1 : $signed({1'b0, r_cell_size});
    assign w_cols  = (r_cols > 5'(GRID_MAX)) ? 5'(GRID_MAX) : r_cols;
    assign w_rows  = (r_rows > 5'(GRID_MAX)) ? 5'(GRID_MAX) : r_rows;
    assign w_ncols = $signed({27'd0, w_cols});
    assign w_nrows = $signed({27'd0, w_rows});

    assign w_can_push = !r_ovalid || m_axis_tready;

    assign w_offx  = r_sx - r_x_low;
    assign w_offz  = r_sz - r_z_low;
    assign w_offex = r_ex - r_x_low;
    assign w_offez = r_ez - r_z_low;

    assign w_reject = !r_zone_en
        || (r_sx < r_x_low && r_ex < r_x_low) || (r_sx > r_x_high && r_ex > r_x_high)
        || (r_sz < r_z_low && r_ez < r_z_low) || (r_sz > r_z_high && r_ez > r_z_high);

    assign w_pcx = (r_cx == w_ncols) ? r_cx - 32'sd1 : r_cx;
    assign w_pcz = (r_cz == w_nrows) ? r_cz - 32'sd1 : r_cz;

    assign w_dx = r_ex - r_sx;
    assign w_dz = r_ez - r_sz;
    assign w_errx = (r_sx >= r_ex) ? -r_adjx : r_adjx - r_dz;
    assign w_errz = (r_sz >= r_ez) ? r_adjz : r_dx - r_adjz;

    assign w_in_grid = in_grid(r_cx, r_cz, w_ncols, w_nrows);

    // the output register loads a pending cell, or the final result, this cycle
    assign w_opush = (r_state == S_FIN && w_can_push)
                  || (r_state == S_WALK && w_in_grid && r_n < CNT_W'(MAX_OUT)
                      && r_have_pend && w_can_push);

    // edge-by-edge clip terms
    always_comb begin
        cl_cond = 1'b0;
        cl_a    = '0;
        cl_b    = '0;
        cl_c    = '0;
        cl_base = '0;
        unique case (r_k)
            3'd0: begin
                cl_cond = r_sx < r_x_low;
                cl_c    = r_ex - r_sx;
                if (r_sz >= r_ez) begin
                    cl_base = r_ez; cl_a = r_ex - r_x_low; cl_b = r_sz - r_ez;
                end else begin
                    cl_base = r_sz; cl_a = r_x_low - r_sx; cl_b = r_ez - r_sz;
                end
            end
            3'd1: begin
                cl_cond = r_ex < r_x_low;
                cl_c    = r_sx - r_ex;
                if (r_ez >= r_sz) begin
                    cl_base = r_sz; cl_a = r_sx - r_x_low; cl_b = r_ez - r_sz;
                end else begin
                    cl_base = r_ez; cl_a = r_x_low - r_ex; cl_b = r_sz - r_ez;
                end
            end
            3'd2: begin
                cl_cond = r_sx > r_x_high;
                cl_c    = r_sx - r_ex;
                if (r_ez >= r_sz) begin
                    cl_base = r_sz; cl_a = r_sx - r_x_high; cl_b = r_ez - r_sz;
                end else begin
                    cl_base = r_ez; cl_a = r_x_high - r_ex; cl_b = r_sz - r_ez;
                end
            end
            3'd3: begin
                cl_cond = r_ex > r_x_high;
                cl_c    = r_ex - r_sx;
                cl_b    = r_sz - r_ez;
                if (r_sz >= r_ez) begin
                    cl_base = r_ez; cl_a = r_ex - r_x_high;
                end else begin
                    cl_base = r_sz; cl_a = r_x_high - r_sx;
                end
            end
            3'd4: begin
                cl_cond = r_sz < r_z_low;
                cl_c    = r_ez - r_sz;
                if (r_sx >= r_ex) begin
                    cl_base = r_ex; cl_a = r_ez - r_z_low; cl_b = r_sx - r_ex;
                end else begin
                    cl_base = r_sx; cl_a = r_z_low - r_sz; cl_b = r_ex - r_sx;
                end
            end
            3'd5: begin
                cl_cond = r_ez < r_z_low;
                cl_c    = r_sz - r_ez;
                if (r_ex >= r_sx) begin
                    cl_base = r_sx; cl_a = r_sz - r_z_low; cl_b = r_ex - r_sx;
                end else begin
                    cl_base = r_ex; cl_a = r_z_low - r_ez; cl_b = r_sx - r_ex;
                end
            end
            3'd6: begin
                cl_cond = r_sz > r_z_high;
                cl_c    = r_sz - r_ez;
                if (r_ex >= r_sx) begin
                    cl_base = r_sx; cl_a = r_sz - r_z_high; cl_b = r_ex - r_sx;
                end else begin
                    cl_base = r_ex; cl_a = r_z_high - r_ez; cl_b = r_sx - r_ex;
                end
            end
            3'd7: begin
                cl_cond = r_ez > r_z_high;
                cl_c    = r_ez - r_sz;
                if (r_sx >= r_ex) begin
                    cl_base = r_ex; cl_a = r_ez - r_z_high; cl_b = r_sx - r_ex;
                end else begin
                    cl_base = r_sx; cl_a = r_z_high - r_sz; cl_b = r_ex - r_sx;
                end
            end
            default: ;
        endcase
    end

    // clip result: direct when the divisor is zero, else after the divider
    assign w_clip_wr  = (r_state == S_CLIP && cl_cond && cl_c == 32'sd0)
                     || (r_state == S_DWAIT && w_rsp.done && r_phase == PH_CLIP);
    assign w_clip_val = (r_state == S_CLIP) ? cl_base : r_base + w_rsp.quo;

    // shared multiplier
    always_comb begin
        unique case (r_state)
            S_MULZ:  begin w_ma = r_dx; w_mb = r_remz; end
            S_MULX:  begin w_ma = r_dz; w_mb = r_remx; end
            default: begin w_ma = cl_a; w_mb = cl_b;   end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    assign w_req.start    = (r_state == S_DSTART);
    assign w_req.dividend = r_dvnd;
    assign w_req.divisor  = r_dvsr;

    scgw_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_CLIP;
            r_zone_en   <= 1'b0;
            r_x_low     <= '0;
            r_z_low     <= '0;
            r_x_high    <= '0;
            r_z_high    <= '0;
            r_cell_size <= 31'd1;
            r_cols      <= 5'd1;
            r_rows      <= 5'd1;
            r_have_pend <= 1'b0;
            r_ovalid    <= 1'b0;
            r_n         <= '0;
            r_k         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ZONE_EN:   r_zone_en   <= i_cfg_data[0];
                    CFG_X_LOW:     r_x_low     <= $signed(i_cfg_data);
                    CFG_Z_LOW:     r_z_low     <= $signed(i_cfg_data);
                    CFG_X_HIGH:    r_x_high    <= $signed(i_cfg_data);
                    CFG_Z_HIGH:    r_z_high    <= $signed(i_cfg_data);
                    CFG_CELL_SIZE: r_cell_size <= i_cfg_data[30:0];
                    CFG_COLS:      r_cols      <= i_cfg_data[4:0];
                    CFG_ROWS:      r_rows      <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            if (w_opush) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            if (w_clip_wr) begin
                unique case (r_k)
                    3'd0: begin r_sz <= w_clip_val; r_sx <= r_x_low;  end
                    3'd1: begin r_ez <= w_clip_val; r_ex <= r_x_low;  end
                    3'd2: begin r_sz <= w_clip_val; r_sx <= r_x_high; end
                    3'd3: begin r_ez <= w_clip_val; r_ex <= r_x_high; end
                    3'd4: begin r_sx <= w_clip_val; r_sz <= r_z_low;  end
                    3'd5: begin r_ex <= w_clip_val; r_ez <= r_z_low;  end
                    3'd6: begin r_sx <= w_clip_val; r_sz <= r_z_high; end
                    3'd7: begin r_ex <= w_clip_val; r_ez <= r_z_high; end
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_sx    <= $signed(s_axis_tdata[31:0]);
                        r_sz    <= $signed(s_axis_tdata[63:32]);
                        r_ex    <= $signed(s_axis_tdata[95:64]);
                        r_ez    <= $signed(s_axis_tdata[127:96]);
                        r_n     <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_reject) begin
                        r_state <= S_FIN;
                    end else if (r_sx == r_ex && r_sz == r_ez) begin
                        r_dvnd  <= 64'(w_offx);
                        r_dvsr  <= w_cs;
                        r_phase <= PH_PTX;
                        r_state <= S_DSTART;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_CLIP;
                    end
                end
                S_CLIP: begin
                    if (cl_cond && cl_c != 32'sd0) begin
                        r_dvnd  <= w_prod;
                        r_dvsr  <= cl_c;
                        r_base  <= cl_base;
                        r_phase <= PH_CLIP;
                        r_state <= S_DSTART;
                    end else begin
                        r_k <= r_k + 3'd1;
                        if (r_k == 3'd7) begin
                            r_state <= S_CELL;
                        end
                    end
                end
                S_CELL: begin
                    r_dvnd  <= 64'(w_offx);
                    r_dvsr  <= w_cs;
                    r_phase <= PH_SCX;
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_rsp.done) begin
                        unique case (r_phase)
                            PH_CLIP: begin
                                r_k     <= r_k + 3'd1;
                                r_state <= (r_k == 3'd7) ? S_CELL : S_CLIP;
                            end
                            PH_PTX: begin
                                r_cx    <= w_rsp.quo;
                                r_dvnd  <= 64'(w_offz);
                                r_phase <= PH_PTZ;
                                r_state <= S_DSTART;
                            end
                            PH_PTZ: begin
                                r_cz    <= w_rsp.quo;
                                r_state <= S_PTEND;
                            end
                            PH_SCX: begin
                                r_cx    <= w_rsp.quo;
                                r_remx  <= w_rsp.rem;
                                r_dvnd  <= 64'(w_offz);
                                r_phase <= PH_SCZ;
                                r_state <= S_DSTART;
                            end
                            PH_SCZ: begin
                                r_cz    <= w_rsp.quo;
                                r_remz  <= w_rsp.rem;
                                r_dvnd  <= 64'(w_offex);
                                r_phase <= PH_ECX;
                                r_state <= S_DSTART;
                            end
                            PH_ECX: begin
                                r_ecx   <= w_rsp.quo;
                                r_dvnd  <= 64'(w_offez);
                                r_phase <= PH_ECZ;
                                r_state <= S_DSTART;
                            end
                            PH_ECZ: begin
                                r_ecz   <= w_rsp.quo;
                                r_state <= S_PREP;
                            end
                            PH_ADJZ: begin
                                r_adjz  <= w_rsp.quo;
                                r_state <= S_MULX;
                            end
                            PH_ADJX: begin
                                r_adjx  <= w_rsp.quo;
                                r_state <= S_ACC;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_PTEND: begin
                    if (in_grid(w_pcx, w_pcz, w_ncols, w_nrows)) begin
                        r_pcol      <= w_pcx[IDX_W-1:0];
                        r_prow      <= w_pcz[IDX_W-1:0];
                        r_have_pend <= 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_PREP: begin
                    // an index equal to the grid size moves back into the last cell
                    if (r_cx == w_ncols) begin
                        r_cx   <= r_cx - 32'sd1;
                        r_remx <= r_remx + w_cs;
                    end
                    if (r_cz == w_nrows) begin
                        r_cz   <= r_cz - 32'sd1;
                        r_remz <= r_remz + w_cs;
                    end
                    if (r_ecx == w_ncols) r_ecx <= r_ecx - 32'sd1;
                    if (r_ecz == w_nrows) r_ecz <= r_ecz - 32'sd1;
                    r_dx      <= w_dx[31] ? r_sx - r_ex : w_dx;
                    r_dz      <= w_dz[31] ? r_sz - r_ez : w_dz;
                    r_stx_neg <= w_dx[31];
                    r_stz_neg <= w_dz[31];
                    r_state   <= S_MULZ;
                end
                S_MULZ: begin
                    r_dvnd  <= w_prod;
                    r_dvsr  <= w_cs;
                    r_phase <= PH_ADJZ;
                    r_state <= S_DSTART;
                end
                S_MULX: begin
                    r_dvnd  <= w_prod;
                    r_dvsr  <= w_cs;
                    r_phase <= PH_ADJX;
                    r_state <= S_DSTART;
                end
                S_ACC: begin
                    r_acc   <= w_errz + w_errx;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (r_cx != r_ecx || r_cz != r_ecz) begin
                        if (!w_in_grid || r_n >= CNT_W'(MAX_OUT)) begin
                            r_state <= S_FIN;
                        end else if (!r_have_pend || w_can_push) begin
                            if (r_have_pend) begin
                                r_ocol   <= r_pcol;
                                r_orow   <= r_prow;
                                r_ouser  <= 1'b1;
                                r_olast  <= 1'b0;
                            end
                            r_pcol      <= r_cx[IDX_W-1:0];
                            r_prow      <= r_cz[IDX_W-1:0];
                            r_have_pend <= 1'b1;
                            r_n         <= r_n + CNT_W'(1);
                            if (r_acc[31]) begin
                                r_acc <= r_acc + r_dx;
                                r_cz  <= r_stz_neg ? r_cz - 32'sd1 : r_cz + 32'sd1;
                            end else begin
                                r_acc <= r_acc - r_dz;
                                r_cx  <= r_stx_neg ? r_cx - 32'sd1 : r_cx + 32'sd1;
                            end
                        end
                    end else if (!w_in_grid || r_n >= CNT_W'(MAX_OUT)) begin
                        r_state <= S_FIN;
                    end else if (!r_have_pend || w_can_push) begin
                        if (r_have_pend) begin
                            r_ocol   <= r_pcol;
                            r_orow   <= r_prow;
                            r_ouser  <= 1'b1;
                            r_olast  <= 1'b0;
                        end
                        r_pcol      <= r_cx[IDX_W-1:0];
                        r_prow      <= r_cz[IDX_W-1:0];
                        r_have_pend <= 1'b1;
                        r_n         <= r_n + CNT_W'(1);
                        r_state     <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_can_push) begin
                        r_ocol      <= r_have_pend ? r_pcol : '0;
                        r_orow      <= r_have_pend ? r_prow : '0;
                        r_ouser     <= r_have_pend;
                        r_olast     <= 1'b1;
                        r_have_pend <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_orow, r_ocol};
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(MAX_OUT))
        else $error("cell count past cap");

    a_invalid_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("invalid result not marked last");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[4:0] < 5'(GRID_MAX) && m_axis_tdata[9:5] < 5'(GRID_MAX))
        else $error("cell index out of grid");

    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_have_pend)
        else $error("pending cell left at idle");
`endif

endmodule
